// File: hw/rtl/stq_pkg.sv
package stq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [2:0] OP_DELAY     = 3'd0;
  localparam logic [2:0] OP_TIMER     = 3'd1;
  localparam logic [2:0] OP_RM_TASK   = 3'd2;
  localparam logic [2:0] OP_RM_TIMER  = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;

  // result kinds
  localparam logic [2:0] K_TASK     = 3'd0;
  localparam logic [2:0] K_TIMER    = 3'd1;
  localparam logic [2:0] K_NOTIMER  = 3'd2;
  localparam logic [2:0] K_DONE     = 3'd3;
  localparam logic [2:0] K_FULL     = 3'd4;
  localparam logic [2:0] K_NOTFOUND = 3'd5;

  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  id;
    logic        is_timer;
    logic [31:0] period;
    logic        reload;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       add;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       ins;
    logic       rem;
    logic       snap;
    logic       reload;
    logic       out_load;
    logic [2:0] kind;
    logic       last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic ptr_end;
    logic le;
    logic match;
    logic head_due;
    logic head_timer;
    logic head_rl;
    logic out_busy;
  } stat_t;

endpackage

// File: hw/rtl/sorted_timeout_queue.sv
// channel  | handshake           | payload
// input    | in_valid / in_stall | op, current_tick, item_id, delay_ms,
//          |                     | timer_deadline, timer_period, auto_reload
// result   | out_valid/out_stall | kind, result_id, last
// config   | cfg_wen             | cfg_wdata (ticks_per_ms)
//
// one transaction at a time; a search or removal walks the entries, one
// entry a cycle, and a delay item first does a multiply and saturating add
// an expiry check releases due entries one at a time, and a reloaded timer
// is re-inserted by another walk
// synchronous active-high reset empties the queue and sets ticks_per_ms to 1
// a stalled result only holds the sequencer in its response step
module sorted_timeout_queue import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [31:0] current_tick,
  input  logic [7:0]  item_id,
  input  logic [31:0] delay_ms,
  input  logic [31:0] timer_deadline,
  input  logic [31:0] timer_period,
  input  logic        auto_reload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  result_id,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry store and arithmetic
  stq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .op             (op),
    .current_tick   (current_tick),
    .item_id        (item_id),
    .delay_ms       (delay_ms),
    .timer_deadline (timer_deadline),
    .timer_period   (timer_period),
    .auto_reload    (auto_reload),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .result_id      (result_id),
    .last           (last)
  );

endmodule

// File: hw/rtl/stq_datapath.sv
module stq_datapath import stq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic [2:0]  op,
  input  logic [31:0] current_tick,
  input  logic [7:0]  item_id,
  input  logic [31:0] delay_ms,
  input  logic [31:0] timer_deadline,
  input  logic [31:0] timer_period,
  input  logic        auto_reload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  result_id,
  output logic        last
);

  logic [15:0]      ticks_per_ms;
  entry_t           entries [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic [2:0]       op_r;
  logic [31:0]      tick;
  logic [31:0]      dur;
  logic [31:0]      delta;
  logic [31:0]      key;
  entry_t           new_e;
  entry_t           ins_e;
  entry_t           head;
  logic [47:0]      prod;
  logic [32:0]      sum_add;
  logic [32:0]      sum_rel;
  entry_t           cur;

  assign prod    = dur * {16'd0, ticks_per_ms};
  assign sum_add = {1'b0, tick} + {1'b0, delta};
  assign sum_rel = {1'b0, head.deadline} + {1'b0, head.period};
  assign cur     = entries[ptr[IDX_W-1:0]];

  // entry written on insert: staged fields with the resolved deadline
  always_comb begin
    ins_e          = new_e;
    ins_e.deadline = key;
  end

  // status towards the controller
  always_comb begin
    stat.full       = (count == CNT_W'(CAPACITY));
    stat.ptr_end    = (ptr == count);
    stat.le         = (cur.deadline <= key);
    stat.match      = (cur.is_timer == (op_r == OP_RM_TIMER)) && (cur.id == new_e.id);
    stat.head_due   = (count != '0) && (entries[0].deadline <= tick);
    stat.head_timer = head.is_timer;
    stat.head_rl    = head.reload;
    stat.out_busy   = out_valid && out_stall;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_ms <= 16'd1;
    end else if (cfg_wen) begin
      ticks_per_ms <= cfg_wdata;
    end
  end

  // operand capture, key arithmetic and head snapshot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r           <= op;
      tick           <= current_tick;
      dur            <= delay_ms;
      key            <= timer_deadline;
      new_e.deadline <= timer_deadline;
      new_e.id       <= item_id;
      new_e.is_timer <= (op == OP_TIMER);
      new_e.period   <= (op == OP_TIMER) ? timer_period : 32'd0;
      new_e.reload   <= (op == OP_TIMER) ? auto_reload : 1'b0;
    end
    if (cmd.mul) begin
      delta <= (prod[47:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
    end
    if (cmd.add) begin
      key <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
    end
    if (cmd.snap) begin
      head <= entries[0];
    end
    if (cmd.reload) begin
      key            <= sum_rel[32] ? 32'hFFFF_FFFF : sum_rel[31:0];
      new_e.id       <= head.id;
      new_e.is_timer <= 1'b1;
      new_e.period   <= head.period;
      new_e.reload   <= 1'b1;
    end
  end

  // walk pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.ins) begin
        count <= count + 1'b1;
      end else if (cmd.rem) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry cells: shift right on insert, left on removal
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.ins) begin
        if (IDX_W'(i) == ptr[IDX_W-1:0]) begin
          entries[i] <= ins_e;
        end else if (i > 0 && IDX_W'(i) > ptr[IDX_W-1:0]) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.rem) begin
        if (i < CAPACITY - 1 && IDX_W'(i) >= ptr[IDX_W-1:0]) begin
          entries[i] <= entries[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind      <= cmd.kind;
      last      <= cmd.last;
      result_id <= (cmd.kind == K_TASK || cmd.kind == K_TIMER) ? head.id : 8'd0;
    end
  end

endmodule

// File: hw/rtl/stq_ctrl.sv
module stq_ctrl import stq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ADD, S_SEARCH, S_INSERT, S_FIND, S_CHECK, S_POPPED, S_RESP
  } state_t;

  state_t     state;
  state_t     ret;
  logic [2:0] rkind;
  logic       rlast;
  logic       reinsert;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.kind     = rkind;
    cmd.last     = rlast;
    cmd.load     = accept;
    cmd.ptr_clr  = accept;
    cmd.mul      = (state == S_MUL);
    cmd.add      = (state == S_ADD);
    cmd.ptr_inc  = ((state == S_SEARCH) && !stat.ptr_end && stat.le) ||
                   ((state == S_FIND) && !stat.ptr_end && !stat.match);
    cmd.ins      = (state == S_INSERT);
    cmd.rem      = ((state == S_FIND) && !stat.ptr_end && stat.match) ||
                   ((state == S_CHECK) && stat.head_due);
    cmd.snap     = (state == S_CHECK) && stat.head_due;
    cmd.reload   = (state == S_POPPED) && stat.head_timer && stat.head_rl;
    if (cmd.reload) begin
      cmd.ptr_clr = 1'b1;
    end
    cmd.out_load = (state == S_RESP) && !stat.out_busy;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      rkind    <= K_DONE;
      rlast    <= 1'b1;
      reinsert <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          reinsert <= 1'b0;
          rlast    <= 1'b1;
          ret      <= S_IDLE;
          if (accept) begin
            case (op)
              OP_DELAY: state <= S_MUL;
              OP_TIMER: begin
                if (stat.full) begin
                  rkind <= K_FULL;
                  state <= S_RESP;
                end else begin
                  state <= S_SEARCH;
                end
              end
              OP_RM_TASK, OP_RM_TIMER: state <= S_FIND;
              OP_CHECK: state <= S_CHECK;
              default: begin
                rkind <= K_DONE;
                state <= S_RESP;
              end
            endcase
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: begin
          if (stat.full) begin
            rkind <= K_FULL;
            state <= S_RESP;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (stat.ptr_end || !stat.le) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          rkind <= reinsert ? K_TIMER : K_DONE;
          rlast <= 1'b1;
          ret   <= S_IDLE;
          state <= S_RESP;
        end
        S_FIND: begin
          if (stat.ptr_end) begin
            rkind <= K_NOTFOUND;
            state <= S_RESP;
          end else if (stat.match) begin
            rkind <= K_DONE;
            state <= S_RESP;
          end
        end
        S_CHECK: begin
          if (stat.head_due) begin
            state <= S_POPPED;
          end else begin
            rkind <= K_NOTIMER;
            rlast <= 1'b1;
            ret   <= S_IDLE;
            state <= S_RESP;
          end
        end
        S_POPPED: begin
          if (!stat.head_timer) begin
            rkind <= K_TASK;
            rlast <= 1'b0;
            ret   <= S_CHECK;
            state <= S_RESP;
          end else if (stat.head_rl) begin
            reinsert <= 1'b1;
            state    <= S_SEARCH;
          end else begin
            rkind <= K_TIMER;
            rlast <= 1'b1;
            ret   <= S_IDLE;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!stat.out_busy) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/stq_checker.sv
module stq_checker import stq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] result_id,
  input logic       last
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // only released tasks leave a list open
  a_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> kind == K_TASK)
    else $error("non-final result of wrong kind");

  // status results carry no identifier
  a_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_TASK && kind != K_TIMER |-> result_id == 8'd0)
    else $error("status result with identifier");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .result_id (result_id),
  .last      (last)
);

// File: tb/sv/tb_sorted_timeout_queue.sv
module tb_sorted_timeout_queue;
  import stq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  op = '0;
  logic [31:0] current_tick = '0;
  logic [7:0]  item_id = '0;
  logic [31:0] delay_ms = '0;
  logic [31:0] timer_deadline = '0;
  logic [31:0] timer_period = '0;
  logic        auto_reload = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  result_id;
  logic        last;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] id;
    logic       last;
  } result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] tick;
    logic [7:0]  id;
    logic [31:0] dur;
    logic [31:0] tdl;
    logic [31:0] tper;
    logic        rl;
    logic        has_exp;
    result_t     exp;
  } row_t;

  sorted_timeout_queue u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .current_tick(current_tick), .item_id(item_id), .delay_ms(delay_ms),
    .timer_deadline(timer_deadline), .timer_period(timer_period),
    .auto_reload(auto_reload), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .result_id(result_id), .last(last)
  );

  always #10 clk = ~clk;

  // predictor state
  entry_t      sched_q[$];
  logic [15:0] tpm;
  result_t     pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          quiet_tail = 1'b0;
  bit          hold_off = 1'b0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit sched_insert(entry_t e);
    int pos;
    pos = 0;
    if (sched_q.size() >= CAPACITY) return 1'b0;
    while (pos < sched_q.size() && sched_q[pos].deadline <= e.deadline) pos++;
    sched_q.insert(pos, e);
    return 1'b1;
  endfunction

  function automatic void push_result(logic [2:0] k, logic [7:0] id, logic l);
    result_t r;
    r.kind = k;
    r.id = id;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // work out the results of one accepted transaction
  function automatic void predict_queue(row_t t);
    entry_t e;
    logic [63:0] prod;
    logic [31:0] delta;
    bit hit;
    int i;
    case (t.op)
      OP_DELAY, OP_TIMER: begin
        if (t.op == OP_DELAY) begin
          prod = t.dur * {48'd0, tpm};
          delta = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
          e = '{deadline: add_sat(t.tick, delta), id: t.id, is_timer: 1'b0,
                period: '0, reload: 1'b0};
        end else begin
          e = '{deadline: t.tdl, id: t.id, is_timer: 1'b1, period: t.tper,
                reload: t.rl};
        end
        push_result(sched_insert(e) ? K_DONE : K_FULL, 8'd0, 1'b1);
      end
      OP_RM_TASK, OP_RM_TIMER: begin
        hit = 1'b0;
        for (i = 0; !hit && i < sched_q.size(); i++) begin
          if (sched_q[i].is_timer == (t.op == OP_RM_TIMER) && sched_q[i].id == t.id) begin
            sched_q.delete(i);
            hit = 1'b1;
          end
        end
        push_result(hit ? K_DONE : K_NOTFOUND, 8'd0, 1'b1);
      end
      OP_CHECK: begin
        while (sched_q.size() > 0 && sched_q[0].deadline <= t.tick) begin
          e = sched_q.pop_front();
          if (!e.is_timer) begin
            push_result(K_TASK, e.id, 1'b0);
          end else begin
            if (e.reload) begin
              e.deadline = add_sat(e.deadline, e.period);
              void'(sched_insert(e));
            end
            push_result(K_TIMER, e.id, 1'b1);
            return;
          end
        end
        push_result(K_NOTIMER, 8'd0, 1'b1);
      end
      default: push_result(K_DONE, 8'd0, 1'b1);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction kind=%0d id=%0d last=%0b", kind, result_id, last);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind || result_id !== want.id || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d id=%0d last=%0b got kind=%0d id=%0d last=%0b",
                     want.kind, want.id, want.last, kind, result_id, last);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls: random bursts, a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (n = 0; n < 600; n++) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(row_t t);
    op <= t.op;
    current_tick <= t.tick;
    item_id <= t.id;
    delay_ms <= t.dur;
    timer_deadline <= t.tdl;
    timer_period <= t.tper;
    auto_reload <= t.rl;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_queue(t);
    if (t.has_exp && pending_results[$] != t.exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row: predictor %p, table %p", pending_results[$], t.exp);
    end
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_tpm(logic [15:0] v);
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    tpm = v;
  endtask

  function automatic row_t mk(logic [2:0] o, logic [31:0] tk, logic [7:0] id,
                              logic [31:0] d, logic [31:0] dl, logic [31:0] p,
                              logic r);
    row_t t;
    t = '{op: o, tick: tk, id: id, dur: d, tdl: dl, tper: p, rl: r,
          has_exp: 1'b0, exp: '0};
    return t;
  endfunction

  function automatic row_t mkx(row_t t, logic [2:0] k);
    t.has_exp = 1'b1;
    t.exp = '{kind: k, id: 8'd0, last: 1'b1};
    return t;
  endfunction

  // random transaction, biased towards a busy queue
  function automatic row_t rand_row(logic [31:0] base);
    row_t t;
    int sel;
    logic [7:0] id;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    if (sel < 30)
      t = mk(OP_DELAY, base, id, ($urandom_range(0, 9) == 0) ? $urandom :
             $urandom_range(0, 200), $urandom, $urandom, 1'($urandom));
    else if (sel < 55)
      t = mk(OP_TIMER, $urandom, id, $urandom,
             ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 400),
             ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300),
             1'($urandom));
    else if (sel < 65)
      t = mk(OP_RM_TASK, $urandom, id, $urandom, $urandom, $urandom, 1'($urandom));
    else if (sel < 75)
      t = mk(OP_RM_TIMER, $urandom, id, $urandom, $urandom, $urandom, 1'($urandom));
    else if (sel < 97)
      t = mk(OP_CHECK, base + $urandom_range(0, 500), id, $urandom, $urandom, $urandom,
             1'($urandom));
    else
      t = mk(3'($urandom_range(5, 7)), $urandom, id, $urandom, $urandom, $urandom,
             1'($urandom));
    return t;
  endfunction

  initial begin
    row_t        table_rows[$];
    logic [31:0] base;
    logic [15:0] tpm_set[4];
    int          i;
    int          ph;
    tpm = 16'd1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows, default ticks_per_ms after reset
    table_rows.push_back(mkx(mk(OP_CHECK, '1, 8'd0, 0, 0, 0, 1'b0), K_NOTIMER));
    table_rows.push_back(mkx(mk(OP_RM_TASK, 0, 8'd9, 0, 0, 0, 1'b0), K_NOTFOUND));
    table_rows.push_back(mkx(mk(OP_RM_TIMER, 0, 8'hFF, 0, 0, 0, 1'b1), K_NOTFOUND));
    table_rows.push_back(mkx(mk(OP_DELAY, '1, 8'hFF, '1, 0, 0, 1'b0), K_DONE));
    table_rows.push_back(mkx(mk(OP_DELAY, 32'd10, 8'd1, 32'd5, 0, 0, 1'b0), K_DONE));
    table_rows.push_back(mkx(mk(OP_TIMER, 0, 8'd2, 0, 32'd15, 32'd0, 1'b1), K_DONE));
    table_rows.push_back(mkx(mk(OP_TIMER, 0, 8'd3, 0, '1, '1, 1'b1), K_DONE));
    table_rows.push_back(mkx(mk(OP_TIMER, 0, 8'd4, 0, 32'd15, 32'd7, 1'b0), K_DONE));
    table_rows.push_back(mkx(mk(3'd5, 0, 8'd0, 0, 0, 0, 1'b0), K_DONE));
    table_rows.push_back(mkx(mk(3'd7, '1, '1, '1, '1, '1, 1'b1), K_DONE));
    table_rows.push_back(mk(OP_CHECK, 32'd15, 8'd0, 0, 0, 0, 1'b0));
    table_rows.push_back(mk(OP_CHECK, 32'd15, 8'd0, 0, 0, 0, 1'b0));
    table_rows.push_back(mk(OP_CHECK, 32'd22, 8'd0, 0, 0, 0, 1'b0));
    table_rows.push_back(mkx(mk(OP_RM_TIMER, 0, 8'd3, 0, 0, 0, 1'b0), K_DONE));
    table_rows.push_back(mkx(mk(OP_RM_TASK, 0, 8'hFF, 0, 0, 0, 1'b0), K_DONE));
    for (i = 0; i < 17; i++)
      table_rows.push_back(mk(OP_DELAY, 32'd100, 8'(i), 32'(i), 0, 0, 1'b0));
    table_rows.push_back(mk(OP_CHECK, '1, 8'd0, 0, 0, 0, 1'b0));
    table_rows.push_back(mk(OP_CHECK, '1, 8'd0, 0, 0, 0, 1'b0));
    foreach (table_rows[j]) send_item(table_rows[j]);
    wait_drained();

    // random phases over a spread of ticks_per_ms settings
    tpm_set = '{16'd0, 16'hFFFF, 16'd1000, 16'($urandom)};
    base = 32'd0;
    for (ph = 0; ph < 4; ph++) begin
      write_tpm(tpm_set[ph]);
      if (ph == 3) quiet_tail = 1'b1;
      if (ph == 1) hold_off = 1'b1;
      for (i = 0; i < 80; i++) begin
        base = (ph == 2 && i == 40) ? 32'hFFFF_FE00 : base + $urandom_range(0, 40);
        send_item(rand_row(base));
      end
      send_item(mk(OP_CHECK, '1, 8'd0, 0, 0, 0, 1'b0));
      wait_drained();
      base = 32'd0;
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_datapath.sv
hw/rtl/stq_ctrl.sv
hw/rtl/sorted_timeout_queue.sv
hw/rtl/stq_checker.sv
tb/sv/tb_sorted_timeout_queue.sv
